// File: hdl/assert_macros.svh
// Assertion macros shared by the extrapolator RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/tle_pkg.sv
// Package for the temperature linear extrapolator.
// Holds field widths, codes and the sequencer state type; depends on nothing.
package tle_pkg;

   localparam int TEMP_WIDTH = 12;
   localparam int STAMP_WIDTH = 48;
   localparam int OUT_WIDTH = 16;
   localparam int MAG_WIDTH = 13;
   localparam int MAG_INDEX_WIDTH = 4;
   localparam int QSEL_WIDTH = 17;
   localparam int PROD_WIDTH = MAG_WIDTH + QSEL_WIDTH;
   localparam int TOTAL_WIDTH = 21;
   localparam int LIN_WIDTH = TOTAL_WIDTH + 1;
   localparam int FRAC_STEPS = 2 * MAG_WIDTH;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_CAP = TOTAL_WIDTH'(1) << (TOTAL_WIDTH - 1);
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 16'sh7fff;
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -16'sh8000;

   localparam logic MODE_READING = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
   localparam logic METHOD_HOLD = 1'b0;
   localparam logic METHOD_LINEAR = 1'b1;

   typedef logic signed [TEMP_WIDTH-1:0] temp_type;
   typedef logic signed [OUT_WIDTH-1:0] out_temp_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIV   = 7'b0000010,
      ST_FRAC  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_TOTAL = 7'b0010000,
      ST_APPLY = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

endpackage

// File: hdl/tle_if.sv
// Valid/ready channel interfaces for the extrapolator's request and response items.
// Depends on tle_pkg for the payload widths.
interface tle_req_if;
   import tle_pkg::*;

   logic valid;
   logic ready;
   logic mode;
   temp_type temperature;
   logic [STAMP_WIDTH-1:0] timestamp;

   modport source (output valid, output mode, output temperature, output timestamp,
                   input ready);
   modport sink (input valid, input mode, input temperature, input timestamp,
                 output ready);
endinterface

interface tle_rsp_if;
   import tle_pkg::*;

   logic valid;
   logic ready;
   logic ok;
   out_temp_type selected_temp;
   out_temp_type hold_temp;
   out_temp_type linear_temp;

   modport source (output valid, output ok, output selected_temp, output hold_temp,
                   output linear_temp, input ready);
   modport sink (input valid, input ok, input selected_temp, input hold_temp,
                 input linear_temp, output ready);
endinterface

// File: hdl/temperature_linear_extrapolator_core.sv
// Top level of the temperature linear extrapolator: slot registers, sequencer,
// shared add/compare unit and result register. Depends on tle_pkg, tle_if.sv
// and assert_macros.svh.
//
// Usage: a request item with mode 0 stores a timestamped reading and gives no
// response; it completes in the accept cycle and the core is ready again in the
// next cycle. A request item with mode 1 is a query and gives one response item.
// A query with fewer than two ordered readings goes straight to the done state
// and then to the response register. Otherwise the shared add/compare unit
// first divides the elapsed time by the reading gap, one quotient bit per
// cycle, then forms the scaled remainder fraction, followed by multiply, total
// and apply steps. The core takes no request while a query is in progress.
// If the receiver stalls, the finished response is held in the output
// register; new readings are still accepted, but a query that finishes waits
// until the held item is taken. Reset clears both reading slots, the method
// register (hold last reading) and any pending response.
`include "assert_macros.svh"

module temperature_linear_extrapolator_core #(
   parameter int TIME_WIDTH = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic csr_wr_data,
   tle_req_if.sink req_ch,
   tle_rsp_if.source rsp_ch
);
   import tle_pkg::*;

   localparam int CNT_WIDTH = $clog2(TIME_WIDTH + 1);

   state_type state_ff, state_in;
   logic method_ff, method_in;
   temp_type prev_temp_ff, prev_temp_in, cur_temp_ff, cur_temp_in;
   logic [TIME_WIDTH-1:0] prev_time_ff, prev_time_in, cur_time_ff, cur_time_in;
   logic prev_valid_ff, prev_valid_in, cur_valid_ff, cur_valid_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [TIME_WIDTH-1:0] acc_ff, acc_in, quo_ff, quo_in, rem_ff, rem_in, gap_ff, gap_in;
   logic [MAG_WIDTH-1:0] mag_ff, mag_in, fq_ff, fq_in;
   logic neg_ff, neg_in, big_ff, big_in;
   logic [PROD_WIDTH-1:0] prod_ff, prod_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   out_temp_type lin_ff, lin_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   out_temp_type rsp_sel_ff, rsp_sel_in, rsp_hold_ff, rsp_hold_in, rsp_lin_ff, rsp_lin_in;

   logic req_take, rsp_take, rsp_free;
   logic [TIME_WIDTH-1:0] now_w, gap_w, elapsed_w;
   logic gap_pos;
   logic signed [MAG_WIDTH-1:0] diff_w;
   logic [TIME_WIDTH-1:0] unit_addend, unit_res;
   logic unit_cin, unit_ge;
   logic [TIME_WIDTH:0] unit_sum, unit_diff;
   logic q_big;
   logic [PROD_WIDTH:0] sum_w;
   logic signed [LIN_WIDTH-1:0] cur_ext, tot_ext, lin_w;
   out_temp_type cur_out, hold_w, linr_w;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take = req_ch.valid && req_ch.ready;
   assign rsp_take = rsp_valid_ff && rsp_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.ok = rsp_ok_ff;
   assign rsp_ch.selected_temp = rsp_sel_ff;
   assign rsp_ch.hold_temp = rsp_hold_ff;
   assign rsp_ch.linear_temp = rsp_lin_ff;

   assign now_w = TIME_WIDTH'(req_ch.timestamp);
   assign gap_pos = cur_time_ff > prev_time_ff;
   assign gap_w = cur_time_ff - prev_time_ff;
   assign elapsed_w = (now_w > cur_time_ff) ? (now_w - cur_time_ff) : '0;
   assign diff_w = MAG_WIDTH'(cur_temp_ff) - MAG_WIDTH'(prev_temp_ff);
   assign cur_out = OUT_WIDTH'(cur_temp_ff);

   // Shared unit: add, then conditionally subtract the gap.
   always_comb begin
      unit_addend = acc_ff;
      unit_cin = 1'b0;
      if (state_ff == ST_DIV) begin
         unit_cin = quo_ff[TIME_WIDTH-1];
      end else if (!cnt_ff[0]) begin
         unit_addend = mag_ff[cnt_ff[MAG_INDEX_WIDTH:1]] ? rem_ff : '0;
      end
   end

   assign unit_sum = {1'b0, acc_ff} + {1'b0, unit_addend} + (TIME_WIDTH + 1)'(unit_cin);
   assign unit_ge = unit_sum >= {1'b0, gap_ff};
   assign unit_diff = unit_sum - {1'b0, gap_ff};
   assign unit_res = unit_ge ? unit_diff[TIME_WIDTH-1:0] : unit_sum[TIME_WIDTH-1:0];

   assign q_big = (quo_ff[TIME_WIDTH-1:QSEL_WIDTH] != '0) ||
                  (quo_ff[QSEL_WIDTH-1] && (quo_ff[QSEL_WIDTH-2:0] != '0));
   assign sum_w = {1'b0, prod_ff} + (PROD_WIDTH + 1)'(fq_ff);

   assign cur_ext = LIN_WIDTH'(cur_temp_ff);
   assign tot_ext = signed'({1'b0, total_ff});
   assign lin_w = neg_ff ? (cur_ext - tot_ext) : (cur_ext + tot_ext);

   assign hold_w = cur_valid_ff ? cur_out : '0;
   assign linr_w = cur_valid_ff ? lin_ff : '0;

   always_comb begin
      state_in = state_ff;
      method_in = csr_wr_en ? csr_wr_data : method_ff;
      prev_temp_in = prev_temp_ff;
      prev_time_in = prev_time_ff;
      prev_valid_in = prev_valid_ff;
      cur_temp_in = cur_temp_ff;
      cur_time_in = cur_time_ff;
      cur_valid_in = cur_valid_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      gap_in = gap_ff;
      mag_in = mag_ff;
      fq_in = fq_ff;
      neg_in = neg_ff;
      big_in = big_ff;
      prod_in = prod_ff;
      total_in = total_ff;
      lin_in = lin_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_ok_in = rsp_ok_ff;
      rsp_sel_in = rsp_sel_ff;
      rsp_hold_in = rsp_hold_ff;
      rsp_lin_in = rsp_lin_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_ch.mode == MODE_READING)) begin
               prev_temp_in = cur_temp_ff;
               prev_time_in = cur_time_ff;
               prev_valid_in = cur_valid_ff;
               cur_temp_in = req_ch.temperature;
               cur_time_in = now_w;
               cur_valid_in = 1'b1;
            end else if (req_take) begin
               lin_in = cur_out;
               acc_in = '0;
               quo_in = elapsed_w;
               gap_in = gap_w;
               neg_in = diff_w[MAG_WIDTH-1];
               mag_in = diff_w[MAG_WIDTH-1] ? MAG_WIDTH'(-diff_w) : MAG_WIDTH'(diff_w);
               fq_in = '0;
               cnt_in = CNT_WIDTH'(TIME_WIDTH - 1);
               state_in = (prev_valid_ff && gap_pos) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            quo_in = {quo_ff[TIME_WIDTH-2:0], unit_ge};
            acc_in = unit_res;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in = unit_res;
               acc_in = '0;
               cnt_in = CNT_WIDTH'(FRAC_STEPS - 1);
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            acc_in = unit_res;
            if (cnt_ff[0]) begin
               fq_in = {fq_ff[MAG_WIDTH-2:0], unit_ge};
            end else begin
               fq_in = fq_ff + MAG_WIDTH'(unit_ge);
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(quo_ff[QSEL_WIDTH-1:0]);
            big_in = q_big && (mag_ff != '0);
            state_in = ST_TOTAL;
         end
         ST_TOTAL: begin
            if (big_ff || (sum_w > (PROD_WIDTH + 1)'(TOTAL_CAP))) begin
               total_in = TOTAL_CAP;
            end else begin
               total_in = sum_w[TOTAL_WIDTH-1:0];
            end
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (lin_w > LIN_WIDTH'(OUT_MAX)) begin
               lin_in = OUT_MAX;
            end else if (lin_w < LIN_WIDTH'(OUT_MIN)) begin
               lin_in = OUT_MIN;
            end else begin
               lin_in = lin_w[OUT_WIDTH-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = cur_valid_ff;
               rsp_hold_in = hold_w;
               rsp_lin_in = linr_w;
               rsp_sel_in = (method_ff == METHOD_LINEAR) ? linr_w : hold_w;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         method_ff <= METHOD_HOLD;
         prev_temp_ff <= '0;
         prev_time_ff <= '0;
         prev_valid_ff <= 1'b0;
         cur_temp_ff <= '0;
         cur_time_ff <= '0;
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         method_ff <= method_in;
         prev_temp_ff <= prev_temp_in;
         prev_time_ff <= prev_time_in;
         prev_valid_ff <= prev_valid_in;
         cur_temp_ff <= cur_temp_in;
         cur_time_ff <= cur_time_in;
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      gap_ff <= gap_in;
      mag_ff <= mag_in;
      fq_ff <= fq_in;
      neg_ff <= neg_in;
      big_ff <= big_in;
      prod_ff <= prod_in;
      total_ff <= total_in;
      lin_ff <= lin_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_sel_ff <= rsp_sel_in;
      rsp_hold_ff <= rsp_hold_in;
      rsp_lin_ff <= rsp_lin_in;
   end

   `ASSERT_NEXT(a_reading_stored, clock, reset,
      req_take && (req_ch.mode == MODE_READING), cur_valid_ff && (state_ff == ST_IDLE))
   `ASSERT_SAME(a_acc_below_gap, clock, reset,
      (state_ff == ST_DIV) || (state_ff == ST_FRAC), acc_ff < gap_ff)
   `ASSERT_SAME(a_frac_below_mag, clock, reset,
      state_ff == ST_MUL, (fq_ff < mag_ff) || (fq_ff == '0))
   `ASSERT_NEXT(a_done_waits, clock, reset,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ch.ready, state_ff == ST_DONE)
   `ASSERT_SAME(a_not_ok_zero, clock, reset,
      rsp_valid_ff && !rsp_ok_ff,
      (rsp_sel_ff == '0) && (rsp_hold_ff == '0) && (rsp_lin_ff == '0))

endmodule
